// ===== rtl/sbus_pkg.sv =====
// shared constants, types and codes of the s-bus frame receiver and decoder
package sbus_pkg;

   // frame geometry
   localparam int FRAME_BYTES   = 25;
   localparam int HEADER_SEARCH = 16;
   localparam int NCHAN         = 16;
   localparam int CHAN_W        = 11;
   localparam int BYTE_W        = 8;
   localparam int STREAM_BYTES  = NCHAN * CHAN_W / BYTE_W;
   localparam int FLAG_POS      = 23;

   // widths
   localparam int IDX_W     = 5;   // frame index 0..FRAME_BYTES
   localparam int HDR_W     = 5;   // header position 0..HEADER_SEARCH
   localparam int ADDR_W    = 6;   // read address, may run past the store
   localparam int CH_IDX_W  = 4;
   localparam int LIMIT_W   = 12;
   localparam int OFF_W     = 4;
   localparam int ACC_W     = CHAN_W - 1 + BYTE_W;
   localparam int NBITS_W   = 5;
   localparam int CSR_IDX_W = 1;

   // command queue
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int CMD_CNT_W = 3;

   // protocol bytes and flag bits
   localparam logic [BYTE_W-1:0] SB_HEADER = 8'h0F;
   localparam logic [BYTE_W-1:0] SB_FOOTER = 8'h00;
   localparam int FLAG_LOST_BIT     = 2;
   localparam int FLAG_FAILSAFE_BIT = 3;

   // register file
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_LIMIT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEADER_OFFSET = 1'b1;
   localparam logic [LIMIT_W-1:0]   CHANNEL_LIMIT_RESET   = 12'd2048;
   localparam logic [OFF_W-1:0]     MAX_OFFSET_RESET      = 4'd0;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_OFFSET = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TAKE,
      ST_FLAG_FETCH,
      ST_FLAG_TAKE,
      ST_EMIT
   } back_state_type;

   // one entry of the front-to-back queue
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              decode;
      logic [HDR_W-1:0]  hdr_off;
   } cmd_type;

   // one decoded result
   typedef struct packed {
      logic [CH_IDX_W-1:0] ch_idx;
      logic [CHAN_W-1:0]   value;
      logic                in_range;
      status_type          status;
      logic                lost;
      logic                failsafe;
      logic                last;
   } rsp_type;

endpackage

// ===== rtl/sbus_front.sv =====
// front end: tracks frame index and header position, issues store and decode commands
module sbus_front import sbus_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [BYTE_W-1:0] rx_byte,
   output cmd_type           cmd,
   output logic              cmd_valid
);

   logic [IDX_W-1:0]  frame_index_ff, frame_index_in;
   logic [BYTE_W-1:0] prev_ff;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [IDX_W-1:0]  idx_eff;
   logic              restart;
   logic              do_wr;
   logic              do_dec;

   always_comb begin
      restart = (rx_byte == SB_HEADER) && (prev_ff == SB_FOOTER);
      idx_eff = restart ? '0 : frame_index_ff;
      do_wr   = idx_eff < IDX_W'(FRAME_BYTES);
      frame_index_in = do_wr ? idx_eff + IDX_W'(1) : idx_eff;

      // first header position among the first HEADER_SEARCH bytes written since the frame restarted
      hdr_in = hdr_ff;
      if (do_wr) begin
         if (idx_eff == '0) begin
            hdr_in = (rx_byte == SB_HEADER) ? '0 : HDR_W'(HEADER_SEARCH);
         end else if ((hdr_ff == HDR_W'(HEADER_SEARCH)) &&
                      (idx_eff < IDX_W'(HEADER_SEARCH)) && (rx_byte == SB_HEADER)) begin
            hdr_in = idx_eff;
         end
      end

      do_dec = (rx_byte == SB_FOOTER) && (frame_index_in == IDX_W'(FRAME_BYTES));

      cmd.wr_en   = do_wr;
      cmd.wr_addr = idx_eff;
      cmd.wr_data = rx_byte;
      cmd.decode  = do_dec;
      cmd.hdr_off = hdr_in;
      cmd_valid   = byte_valid && (do_wr || do_dec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff <= '0;
         prev_ff        <= '0;
         hdr_ff         <= HDR_W'(HEADER_SEARCH);
      end else if (byte_valid) begin
         frame_index_ff <= frame_index_in;
         prev_ff        <= rx_byte;
         hdr_ff         <= hdr_in;
      end
   end

endmodule

// ===== rtl/sbus_cmd_queue.sv =====
// short command queue between front end and decoder
module sbus_cmd_queue import sbus_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type                slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_CNT_W-1:0]   count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CMD_CNT_W'(1);
            2'b01:   count_ff <= count_ff - CMD_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sbus_back.sv =====
// back end: frame memory, bit-stream channel unpacker, flag update and result register
module sbus_back import sbus_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               cmd_avail,
   output logic               cmd_pop,
   input  logic [LIMIT_W-1:0] channel_limit,
   input  logic [OFF_W-1:0]   max_header_offset,
   output rsp_type            rsp,
   output logic               rsp_valid,
   input  logic               rsp_pop
);

   back_state_type state_ff, state_in;

   logic [BYTE_W-1:0]   store_mem [FRAME_BYTES];
   logic [BYTE_W-1:0]   rd_q_ff;
   logic                rd_zero_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [HDR_W-1:0]    off_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [NBITS_W-1:0]  nbits_ff;
   logic [CH_IDX_W-1:0] ch_ff;
   status_type          status_ff;
   logic [NCHAN-1:0]    updated_ff;
   logic [CHAN_W-1:0]   held_ff [NCHAN];
   logic                lost_ff;
   logic                failsafe_ff;
   rsp_type             out_ff;
   logic                out_valid_ff;

   logic                out_free;
   logic                mem_we;
   logic                out_load;
   logic [BYTE_W-1:0]   take_byte;
   logic [ACC_W-1:0]    sum;
   logic [NBITS_W-1:0]  nb;
   logic                have_chan;
   logic [CHAN_W-1:0]   chan_val;
   logic                chan_ok;
   logic                off_ok;
   logic                last_ch;

   // datapath terms
   always_comb begin
      out_free  = !out_valid_ff || rsp_pop;
      take_byte = rd_zero_ff ? '0 : rd_q_ff;
      sum       = acc_ff | (ACC_W'(take_byte) << nbits_ff);
      nb        = nbits_ff + NBITS_W'(BYTE_W);
      have_chan = nb >= NBITS_W'(CHAN_W);
      chan_val  = sum[CHAN_W-1:0];
      chan_ok   = {1'b0, chan_val} < channel_limit;
      off_ok    = cmd.hdr_off <= {1'b0, max_header_offset};
      last_ch   = ch_ff == CH_IDX_W'(NCHAN - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_avail && cmd.decode) begin
               state_in = off_ok ? ST_FETCH : ST_EMIT;
            end
         end
         ST_FETCH:      state_in = ST_TAKE;
         ST_TAKE: begin
            state_in = (have_chan && last_ch) ? ST_FLAG_FETCH : ST_FETCH;
         end
         ST_FLAG_FETCH: state_in = ST_FLAG_TAKE;
         ST_FLAG_TAKE:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free && last_ch) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop  = (state_ff == ST_IDLE) && cmd_avail;
      mem_we   = cmd_pop && cmd.wr_en;
      out_load = (state_ff == ST_EMIT) && out_free;
   end

   // frame memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_q_ff    <= store_mem[rd_addr_ff[IDX_W-1:0]];
      rd_zero_ff <= rd_addr_ff >= ADDR_W'(FRAME_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         lost_ff      <= 1'b0;
         failsafe_ff  <= 1'b0;
         ch_ff        <= '0;
         for (int i = 0; i < NCHAN; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop && cmd.decode) begin
                  off_ff     <= cmd.hdr_off;
                  updated_ff <= '0;
                  ch_ff      <= '0;
                  acc_ff     <= '0;
                  nbits_ff   <= '0;
                  rd_addr_ff <= ADDR_W'(cmd.hdr_off) + ADDR_W'(1);
                  status_ff  <= off_ok ? STATUS_OK : STATUS_OFFSET;
               end
            end
            ST_TAKE: begin
               if (have_chan) begin
                  acc_ff   <= sum >> CHAN_W;
                  nbits_ff <= nb - NBITS_W'(CHAN_W);
                  ch_ff    <= ch_ff + CH_IDX_W'(1);
                  if (chan_ok) begin
                     held_ff[ch_ff]    <= chan_val;
                     updated_ff[ch_ff] <= 1'b1;
                  end else begin
                     status_ff <= STATUS_RANGE;
                  end
                  // after the last channel go fetch the flag byte
                  rd_addr_ff <= last_ch ? ADDR_W'(off_ff) + ADDR_W'(FLAG_POS)
                                        : rd_addr_ff + ADDR_W'(1);
               end else begin
                  acc_ff     <= sum;
                  nbits_ff   <= nb;
                  rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
               end
            end
            ST_FLAG_TAKE: begin
               if (take_byte[FLAG_LOST_BIT]) begin
                  lost_ff <= 1'b1;
               end
               if (take_byte[FLAG_FAILSAFE_BIT]) begin
                  failsafe_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (out_load) begin
                  out_ff.ch_idx   <= ch_ff;
                  out_ff.value    <= held_ff[ch_ff];
                  out_ff.in_range <= updated_ff[ch_ff];
                  out_ff.status   <= status_ff;
                  out_ff.lost     <= lost_ff;
                  out_ff.failsafe <= failsafe_ff;
                  out_ff.last     <= last_ch;
                  ch_ff           <= ch_ff + CH_IDX_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

// ===== rtl/sbus_frame_receiver_decoder.sv =====
// top level of the s-bus frame receiver and decoder
//
//   channel  ports                         handshake          moves
//   req      req_rx_byte                   push / full        one received byte
//   rsp      rsp_channel_index .. last     empty / pop        one decoded channel item
//   csr      csr_index, csr_wdata          csr_we             register write, no wait
//
// a byte is taken when the command queue has room and is queued for the decoder;
// a byte that only stores is popped and written while the back end is idle. a footer
// that completes a frame runs a fetch and a take state per stream byte (22 bytes), then
// the flag byte, then 16 emits, as the frame memory read is registered. a rejected frame only emits.
// reset is synchronous and clears index, flags, held channels and the queues;
// the frame memory itself is not cleared. full rises when the four-entry
// command queue fills; results wait in one output register while pop is low
module sbus_frame_receiver_decoder import sbus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   // decoded channel items
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CH_IDX_W-1:0]  rsp_channel_index,
   output logic [CHAN_W-1:0]    rsp_channel_value,
   output logic                 rsp_value_in_range,
   output logic [1:0]           rsp_frame_status,
   output logic                 rsp_frame_lost_flag,
   output logic                 rsp_failsafe_flag,
   output logic                 rsp_last_of_frame,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   logic [LIMIT_W-1:0] channel_limit_ff;
   logic [OFF_W-1:0]   max_offset_ff;

   logic    byte_take;
   cmd_type front_cmd;
   logic    front_cmd_valid;
   cmd_type queue_head;
   logic    queue_full;
   logic    queue_empty;
   logic    back_pop;
   rsp_type back_rsp;
   logic    back_rsp_valid;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_limit_ff <= CHANNEL_LIMIT_RESET;
         max_offset_ff    <= MAX_OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_LIMIT:     channel_limit_ff <= csr_wdata;
            CSR_MAX_HEADER_OFFSET: max_offset_ff    <= csr_wdata[OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a byte is taken whenever the command queue has room
   assign req_full  = queue_full;
   assign byte_take = req_push && !queue_full;

   sbus_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .rx_byte    (req_rx_byte),
      .cmd        (front_cmd),
      .cmd_valid  (front_cmd_valid)
   );

   // store writes and decode requests stay in order, so later bytes
   // cannot overwrite the frame before it is decoded
   sbus_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_cmd_valid),
      .push_data (front_cmd),
      .pop       (back_pop),
      .head      (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   sbus_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (queue_head),
      .cmd_avail         (!queue_empty),
      .cmd_pop           (back_pop),
      .channel_limit     (channel_limit_ff),
      .max_header_offset (max_offset_ff),
      .rsp               (back_rsp),
      .rsp_valid         (back_rsp_valid),
      .rsp_pop           (rsp_pop)
   );

   // result ports
   assign rsp_empty           = !back_rsp_valid;
   assign rsp_channel_index   = back_rsp.ch_idx;
   assign rsp_channel_value   = back_rsp.value;
   assign rsp_value_in_range  = back_rsp.in_range;
   assign rsp_frame_status    = back_rsp.status;
   assign rsp_frame_lost_flag = back_rsp.lost;
   assign rsp_failsafe_flag   = back_rsp.failsafe;
   assign rsp_last_of_frame   = back_rsp.last;

   // channels of a frame come out in ascending order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_frame) |=>
         (rsp_empty || (rsp_channel_index == $past(rsp_channel_index) + CH_IDX_W'(1))))
      else $error("channel index did not advance within a frame");

   // the frame marker sits on the highest channel only
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_of_frame == (rsp_channel_index == CH_IDX_W'(NCHAN - 1))))
      else $error("last_of_frame out of step with channel index");

   // status stays the same over all items of one frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_frame) |=>
         (rsp_empty || (rsp_frame_status == $past(rsp_frame_status))))
      else $error("frame status changed inside a frame");

endmodule

// ===== verif/sbus_frame_receiver_decoder_checker.sv =====
// channel monitor, frame decode predictor and result comparison for the s-bus decoder
module sbus_frame_receiver_decoder_checker import sbus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic [CH_IDX_W-1:0]  rsp_channel_index,
   input  logic [CHAN_W-1:0]    rsp_channel_value,
   input  logic                 rsp_value_in_range,
   input  logic [1:0]           rsp_frame_status,
   input  logic                 rsp_frame_lost_flag,
   input  logic                 rsp_failsafe_flag,
   input  logic                 rsp_last_of_frame,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);

   logic [BYTE_W-1:0]  frame_mem [FRAME_BYTES];
   logic [IDX_W-1:0]   fill_level;
   logic [BYTE_W-1:0]  last_byte;
   logic [CHAN_W-1:0]  channel_hold [NCHAN];
   logic               lost_seen;
   logic               failsafe_seen;
   logic [LIMIT_W-1:0] limit_reg;
   logic [OFF_W-1:0]   offset_reg;
   rsp_type            expected_channels [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // reads past the stored frame count as zero
   function automatic logic [BYTE_W-1:0] stored_byte(input int pos);
      return (pos < FRAME_BYTES) ? frame_mem[pos] : '0;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type           seen;
      rsp_type           want;
      int                hdr;
      int                bitpos;
      int                base;
      int                n;
      int                k;
      logic [23:0]       word;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] flag_byte;
      logic              took [NCHAN];
      status_type        verdict;
      if (reset) begin
         expected_channels.delete();
         fill_level    = '0;
         last_byte     = SB_FOOTER;
         lost_seen     = 1'b0;
         failsafe_seen = 1'b0;
         limit_reg     = CHANNEL_LIMIT_RESET;
         offset_reg    = MAX_OFFSET_RESET;
         for (k = 0; k < NCHAN; k++) channel_hold[k] = '0;
      end else begin
         // results leave before this edge's byte can add new ones
         if (rsp_pop && !rsp_empty) begin
            seen.ch_idx   = rsp_channel_index;
            seen.value    = rsp_channel_value;
            seen.in_range = rsp_value_in_range;
            seen.status   = status_type'(rsp_frame_status);
            seen.lost     = rsp_frame_lost_flag;
            seen.failsafe = rsp_failsafe_flag;
            seen.last     = rsp_last_of_frame;
            if (expected_channels.size() == 0) begin
               $error("channel item with none expected: channel_index %0d", seen.ch_idx);
               mismatches++;
            end else begin
               want = expected_channels.pop_front();
               if (seen.ch_idx !== want.ch_idx) begin
                  $error("channel_index: expected %0d, got %0d", want.ch_idx, seen.ch_idx);
                  mismatches++;
               end
               if (seen.value !== want.value) begin
                  $error("channel_value: expected %0d, got %0d", want.value, seen.value);
                  mismatches++;
               end
               if (seen.in_range !== want.in_range) begin
                  $error("value_in_range: expected %0d, got %0d",
                         want.in_range, seen.in_range);
                  mismatches++;
               end
               if (seen.status !== want.status) begin
                  $error("frame_status: expected %0d, got %0d", want.status, seen.status);
                  mismatches++;
               end
               if (seen.lost !== want.lost) begin
                  $error("frame_lost_flag: expected %0d, got %0d", want.lost, seen.lost);
                  mismatches++;
               end
               if (seen.failsafe !== want.failsafe) begin
                  $error("failsafe_flag: expected %0d, got %0d",
                         want.failsafe, seen.failsafe);
                  mismatches++;
               end
               if (seen.last !== want.last) begin
                  $error("last_of_frame: expected %0d, got %0d", want.last, seen.last);
                  mismatches++;
               end
            end
         end

         if (csr_we) begin
            if (csr_index == CSR_CHANNEL_LIMIT)
               limit_reg = csr_wdata;
            else if (csr_index == CSR_MAX_HEADER_OFFSET)
               offset_reg = csr_wdata[OFF_W-1:0];
         end

         if (req_push && !req_full) begin
            b = req_rx_byte;
            if (b == SB_HEADER && last_byte == SB_FOOTER) fill_level = '0;
            if (fill_level < FRAME_BYTES) begin
               frame_mem[fill_level] = b;
               fill_level++;
            end
            last_byte = b;

            if (b == SB_FOOTER && fill_level == FRAME_BYTES) begin
               // scan downward so the first header position wins
               hdr = HEADER_SEARCH;
               for (n = HEADER_SEARCH - 1; n >= 0; n--)
                  if (frame_mem[n] == SB_HEADER) hdr = n;
               verdict = STATUS_OK;
               for (k = 0; k < NCHAN; k++) took[k] = 1'b0;

               if (hdr > offset_reg) begin
                  verdict = STATUS_OFFSET;
               end else begin
                  for (k = 0; k < NCHAN; k++) begin
                     bitpos = CHAN_W * k;
                     base   = hdr + 1 + bitpos / BYTE_W;
                     word   = {stored_byte(base + 2), stored_byte(base + 1),
                               stored_byte(base)};
                     word   = word >> (bitpos % BYTE_W);
                     if (word[CHAN_W-1:0] < limit_reg) begin
                        channel_hold[k] = word[CHAN_W-1:0];
                        took[k]         = 1'b1;
                     end else begin
                        verdict = STATUS_RANGE;
                     end
                  end
                  // flags stick regardless of the channel checks
                  flag_byte = stored_byte(hdr + FLAG_POS);
                  if (flag_byte[FLAG_LOST_BIT])     lost_seen     = 1'b1;
                  if (flag_byte[FLAG_FAILSAFE_BIT]) failsafe_seen = 1'b1;
               end

               for (k = 0; k < NCHAN; k++) begin
                  want.ch_idx   = k[CH_IDX_W-1:0];
                  want.value    = channel_hold[k];
                  want.in_range = took[k];
                  want.status   = verdict;
                  want.lost     = lost_seen;
                  want.failsafe = failsafe_seen;
                  want.last     = (k == NCHAN - 1);
                  expected_channels.push_back(want);
               end
            end
         end
      end
      outstanding = expected_channels.size();
   end

endmodule

// ===== verif/sbus_frame_receiver_decoder_tb.sv =====
// stimulus, handshake timing and verdict for the s-bus frame receiver and decoder
module sbus_frame_receiver_decoder_tb;
   import sbus_pkg::*;

   localparam int ITEM_TARGET  = 420;
   localparam int CALM_AFTER   = 360;     // no idling on either side from here on
   localparam int PRESSURE_AT  = 120;
   localparam int DRAIN_CYCLES = 100;     // covers queued store commands after the last item
   localparam int HOLD_CYCLES  = 1000;
   localparam int CYCLE_LIMIT  = 1000000;

   // how the channel bytes of a well-formed frame are filled
   typedef enum int {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS,
      FILL_MIXED
   } fill_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_push  = 1'b0;
   logic                 req_full;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_empty;
   logic                 rsp_pop   = 1'b0;
   logic [CH_IDX_W-1:0]  rsp_channel_index;
   logic [CHAN_W-1:0]    rsp_channel_value;
   logic                 rsp_value_in_range;
   logic [1:0]           rsp_frame_status;
   logic                 rsp_frame_lost_flag;
   logic                 rsp_failsafe_flag;
   logic                 rsp_last_of_frame;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHANNEL_LIMIT;
   logic [LIMIT_W-1:0]   csr_wdata = '0;

   int                   mismatches;
   int                   outstanding;
   int                   sent        = 0;
   int                   cycle_count = 0;
   int                   tx_idle_pct = 20;
   bit                   calm        = 1'b0;
   bit                   hold_rsp    = 1'b0;
   bit                   held_once   = 1'b0;
   logic [BYTE_W-1:0]    last_sent   = SB_FOOTER;

   sbus_frame_receiver_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_value_in_range  (rsp_value_in_range),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_frame_lost_flag (rsp_frame_lost_flag),
      .rsp_failsafe_flag   (rsp_failsafe_flag),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   sbus_frame_receiver_decoder_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_value_in_range  (rsp_value_in_range),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_frame_lost_flag (rsp_frame_lost_flag),
      .rsp_failsafe_flag   (rsp_failsafe_flag),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .outstanding         (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // any byte except the two framing codes
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom); while (b == SB_HEADER || b == SB_FOOTER);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] data_byte(input fill_type fill);
      case (fill)
         FILL_ONES:  return 8'hFF;
         FILL_ZEROS: return 8'h00;
         FILL_MIXED: begin
            case ($urandom_range(0, 2))
               0:       return 8'h00;
               1:       return 8'hFF;
               default: return BYTE_W'($urandom);
            endcase
         end
         default:    return BYTE_W'($urandom);
      endcase
   endfunction

   // offer one byte, possibly after an idle burst, and hold it until taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      sent++;
      last_sent = b;
      if (sent >= CALM_AFTER) calm = 1'b1;
   endtask

   // stop offering, let every expected item drain, then let the back end settle
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back
   task automatic write_csrs(input logic [LIMIT_W-1:0] channel_limit,
                             input logic [OFF_W-1:0]   header_reach);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_LIMIT;
      csr_wdata <= channel_limit;
      @(posedge clock);
      csr_index <= CSR_MAX_HEADER_OFFSET;
      csr_wdata <= LIMIT_W'(header_reach);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // footer (if needed to arm the restart), header, 22 channel bytes, flags, footer
   task automatic send_frame();
      fill_type          fill;
      logic [BYTE_W-1:0] flags;
      int                i;
      fill = fill_type'($urandom_range(0, 3));
      if (last_sent != SB_FOOTER) send_byte(SB_FOOTER);
      send_byte(SB_HEADER);
      for (i = 0; i < STREAM_BYTES; i++) send_byte(data_byte(fill));
      // lost and failsafe are sticky, so set them only now and then
      flags = BYTE_W'($urandom);
      flags[FLAG_LOST_BIT]     = ($urandom_range(0, 11) == 0);
      flags[FLAG_FAILSAFE_BIT] = ($urandom_range(0, 11) == 0);
      send_byte(flags);
      send_byte(SB_FOOTER);
   endtask

   // result side: random pop bursts, one long hold-off to back the block up
   initial begin : rsp_side
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp && !held_once) begin
            held_once = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_pop <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int                 i;
      int                 hdr_pos;
      int                 pick;
      logic [LIMIT_W-1:0] channel_limit;
      logic [OFF_W-1:0]   header_reach;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_csrs(CHANNEL_LIMIT_RESET, MAX_OFFSET_RESET);

      // the store can only hold a shifted header before the first restart, so
      // the opening frame puts it at the last searched position or leaves it out
      hdr_pos = $urandom_range(0, 1) ? HEADER_SEARCH - 1 : HEADER_SEARCH;
      for (i = 0; i < FRAME_BYTES - 1; i++)
         send_byte((i == hdr_pos) ? SB_HEADER : plain_byte());
      // offset beyond zero reach: rejected, held values and flags unchanged
      send_byte(SB_FOOTER);

      // full store: each further footer decodes the same frame again; with the
      // header at the far end the unpacker runs past the store and reads zeros
      wait_idle();
      write_csrs(12'd2048, 4'd15);
      send_byte(SB_FOOTER);
      wait_idle();
      write_csrs(12'd2047, 4'd15);
      send_byte(SB_FOOTER);

      // random phases, each under its own register setting
      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       channel_limit = 12'd0;
            1:       channel_limit = 12'd1;
            2:       channel_limit = 12'd2047;
            3:       channel_limit = 12'd2048;
            4:       channel_limit = LIMIT_W'($urandom_range(0, 2048));
            default: channel_limit = LIMIT_W'($urandom_range(1024, 2048));
         endcase
         case ($urandom_range(0, 2))
            0:       header_reach = 4'd0;
            1:       header_reach = 4'd15;
            default: header_reach = OFF_W'($urandom_range(0, 15));
         endcase
         case ($urandom_range(0, 2))
            0:       tx_idle_pct = 0;
            1:       tx_idle_pct = 10;
            default: tx_idle_pct = 35;
         endcase
         wait_idle();
         write_csrs(channel_limit, header_reach);

         // two frames against a stalled receiver so the command queue fills
         if (!hold_rsp && sent >= PRESSURE_AT) begin
            hold_rsp = 1'b1;
            send_frame();
            send_frame();
         end

         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_frame();
            end else if (pick == 7) begin
               // line noise, rich in framing codes
               repeat ($urandom_range(1, 12))
                  send_byte(($urandom_range(0, 2) == 0) ? SB_FOOTER :
                            ($urandom_range(0, 2) == 0) ? SB_HEADER : 8'($urandom));
            end else if (pick == 8) begin
               // frame cut short, the next one restarts over it
               if (last_sent != SB_FOOTER) send_byte(SB_FOOTER);
               send_byte(SB_HEADER);
               repeat ($urandom_range(1, 20)) send_byte(BYTE_W'($urandom));
            end else begin
               // extra footers redecode a full store
               repeat ($urandom_range(1, 3)) send_byte(SB_FOOTER);
            end
         end
      end

      wait_idle();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
